/* hdl/cc20_pkg.sv */
`default_nettype none

package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	// Sequencer commands to the round datapath.
	typedef struct packed {
		logic       load;
		logic       step;
		logic       fin;
		logic       diag;
		logic [1:0] sub;
	} ctl_t;

	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646E;
	localparam word_t SIGMA2 = 32'h79622D32;
	localparam word_t SIGMA3 = 32'h6B206574;

	localparam int BLOCK_BYTES = 64;
	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_KEY01   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY23   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEY45   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEY67   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COUNTER = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NONCE01 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_NONCE2  = 3'd6;

endpackage

`default_nettype wire

/* hdl/cc20_round.sv */
`default_nettype none

module cc20_round
	import cc20_pkg::*;
(
	input  wire logic   clk,
	input  wire ctl_t   ctl,
	input  wire state_t init,
	output state_t      ks
);

	state_t st_q;
	state_t st_nxt;
	word_t  a [4];
	word_t  b [4];
	word_t  c [4];
	word_t  d [4];
	word_t  x [4];
	word_t  t [4];
	word_t  y [4];
	word_t  na [4];
	word_t  nb [4];
	word_t  nc [4];
	word_t  nd [4];

	// Four quarter-round lanes, each doing one add, xor and rotate per cycle.
	// On a diagonal round the rows are read rotated so that lane i works on
	// the diagonal that starts at word i.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a[i] = st_q[i];
			b[i] = ctl.diag ? st_q[4 + ((i + 1) % 4)] : st_q[4 + i];
			c[i] = ctl.diag ? st_q[8 + ((i + 2) % 4)] : st_q[8 + i];
			d[i] = ctl.diag ? st_q[12 + ((i + 3) % 4)] : st_q[12 + i];
			x[i] = ctl.sub[0] ? (c[i] + d[i]) : (a[i] + b[i]);
			t[i] = ctl.sub[0] ? (b[i] ^ x[i]) : (d[i] ^ x[i]);
			unique case (ctl.sub)
				2'd0: y[i] = {t[i][15:0], t[i][31:16]};
				2'd1: y[i] = {t[i][19:0], t[i][31:20]};
				2'd2: y[i] = {t[i][23:0], t[i][31:24]};
				2'd3: y[i] = {t[i][24:0], t[i][31:25]};
				default: y[i] = t[i];
			endcase
			na[i] = ctl.sub[0] ? a[i] : x[i];
			nd[i] = ctl.sub[0] ? d[i] : y[i];
			nc[i] = ctl.sub[0] ? x[i] : c[i];
			nb[i] = ctl.sub[0] ? y[i] : b[i];
		end
		for (int j = 0; j < 4; j++) begin
			st_nxt[j]      = na[j];
			st_nxt[4 + j]  = ctl.diag ? nb[(j + 3) % 4] : nb[j];
			st_nxt[8 + j]  = ctl.diag ? nc[(j + 2) % 4] : nc[j];
			st_nxt[12 + j] = ctl.diag ? nd[(j + 1) % 4] : nd[j];
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			st_q <= init;
		end else if (ctl.step) begin
			st_q <= st_nxt;
		end else if (ctl.fin) begin
			for (int k = 0; k < 16; k++) begin
				st_q[k] <= st_q[k] + init[k];
			end
		end
	end

	assign ks = st_q;

endmodule

`default_nettype wire

/* hdl/cc20_ctrl.sv */
`default_nettype none

module cc20_ctrl
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
)
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic abort,
	output ctl_t      ctl
);

	localparam int DR_W = $clog2(DOUBLE_ROUNDS);
	localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_FINAL
	} fsm_t;

	fsm_t            state_q;
	logic [2:0]      step_q;
	logic [DR_W-1:0] dr_q;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = start && !abort;
			end
			S_ROUND: begin
				ctl.step = 1'b1;
				ctl.diag = step_q[2];
				ctl.sub  = step_q[1:0];
			end
			S_FINAL: begin
				ctl.fin = !abort;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	// The step counter walks four column steps and then four diagonal steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			dr_q    <= '0;
		end else if (abort) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			dr_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_ROUND;
						step_q  <= '0;
						dr_q    <= '0;
					end
				end
				S_ROUND: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						dr_q <= dr_q + DR_W'(1);
						if (dr_q == DR_LAST) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.step, ctl.fin}))
		else $error("more than one datapath command at once");

	a_load_round: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> state_q == S_ROUND)
		else $error("block load not followed by rounds");

	a_round_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && step_q == 3'd3) |=> (ctl.diag || state_q != S_ROUND))
		else $error("diagonal half not reached after column half");

endmodule

`default_nettype wire

/* hdl/chacha20_stream_xor.sv */
`default_nettype none

// ChaCha20 (96-bit nonce) stream XOR, one byte per word on the input channel.
// While a keystream block is ready and the output is not stalled, a byte is taken
// every cycle and its result appears in the output register on the next cycle.
// A block is built after reset, after every 64 bytes, after a byte marked last
// and after any write to a known configuration register: a load, eight round
// steps per double round and a feed-forward, during which the input is stalled.
// The build time is set by the four-lane quarter-round step unit, which
// performs one add, xor and rotate per lane per cycle. Configuration
// writes are always taken; a write to a known register restarts the block.
module chacha20_stream_xor
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           data_in,
	input  wire logic                 last_in,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                data_out,
	output logic                      last_out,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data
);

	logic [63:0]      key01_q;
	logic [63:0]      key23_q;
	logic [63:0]      key45_q;
	logic [63:0]      key67_q;
	logic [63:0]      nonce01_q;
	word_t            nonce2_q;
	word_t            block_counter_q;
	logic [POS_W-1:0] pos_q;
	logic             ks_valid_q;
	logic             out_valid_q;
	logic [7:0]       data_out_q;
	logic             last_out_q;

	logic   cfg_wr;
	logic   cfg_hit;
	logic   in_acc;
	logic   wrap;
	ctl_t   ctl;
	state_t init;
	state_t ks;
	word_t  ks_word;
	logic [7:0] ks_byte;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		unique case (cfg_index)
			REG_KEY01, REG_KEY23, REG_KEY45, REG_KEY67,
			REG_COUNTER, REG_NONCE01, REG_NONCE2: cfg_hit = cfg_wr;
			default: cfg_hit = 1'b0;
		endcase
	end

	assign in_stall = !ks_valid_q || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign wrap     = (pos_q == POS_LAST) || last_in;

	always_comb begin
		init[0]  = SIGMA0;
		init[1]  = SIGMA1;
		init[2]  = SIGMA2;
		init[3]  = SIGMA3;
		init[4]  = key01_q[31:0];
		init[5]  = key01_q[63:32];
		init[6]  = key23_q[31:0];
		init[7]  = key23_q[63:32];
		init[8]  = key45_q[31:0];
		init[9]  = key45_q[63:32];
		init[10] = key67_q[31:0];
		init[11] = key67_q[63:32];
		init[12] = block_counter_q;
		init[13] = nonce01_q[31:0];
		init[14] = nonce01_q[63:32];
		init[15] = nonce2_q;
	end

	cc20_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (!ks_valid_q),
		.abort (cfg_hit),
		.ctl   (ctl)
	);

	cc20_round u_round (
		.clk (clk),
		.ctl (ctl),
		.init(init),
		.ks  (ks)
	);

	// Keystream bytes are taken little-endian, word 0 first.
	assign ks_word = ks[pos_q[POS_W-1:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q         <= '0;
			key23_q         <= '0;
			key45_q         <= '0;
			key67_q         <= '0;
			nonce01_q       <= '0;
			nonce2_q        <= '0;
			block_counter_q <= '0;
			pos_q           <= '0;
			ks_valid_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_KEY01:   key01_q <= cfg_data;
					REG_KEY23:   key23_q <= cfg_data;
					REG_KEY45:   key45_q <= cfg_data;
					REG_KEY67:   key67_q <= cfg_data;
					REG_COUNTER: block_counter_q <= cfg_data[31:0];
					REG_NONCE01: nonce01_q <= cfg_data;
					REG_NONCE2:  nonce2_q <= cfg_data[31:0];
					default: begin
					end
				endcase
			end
			priority if (cfg_hit) begin
				pos_q      <= '0;
				ks_valid_q <= 1'b0;
			end else if (in_acc) begin
				if (wrap) begin
					block_counter_q <= block_counter_q + 32'd1;
					pos_q           <= '0;
					ks_valid_q      <= 1'b0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else if (ctl.fin) begin
				ks_valid_q <= 1'b1;
			end
			out_valid_q <= in_acc || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_out_q <= data_in ^ ks_byte;
			last_out_q <= last_in;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign last_out  = last_out_q;

	a_fresh_block: assert property (@(posedge clk) disable iff (!arst_n)
		!ks_valid_q |-> pos_q == '0)
		else $error("byte position not at block start while keystream is missing");

	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_acc))
		else $error("output word without an accepted input word");

	a_block_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fin && !cfg_hit) |=> ks_valid_q)
		else $error("finished block not marked ready");

endmodule

`default_nettype wire

/* verif/tb_chacha20_stream_xor.sv */
`default_nettype none

module tb_chacha20_stream_xor;
	import cc20_pkg::*;

	localparam int ROUNDS = 10;
	// Long enough for a full keystream block build, with margin on top.
	localparam int BUILD_WAIT = 8 * ROUNDS + 40;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 105;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_byte_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_in = '0;
	logic                 last_in = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           data_out;
	logic                 last_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	chacha20_stream_xor #(
		.DOUBLE_ROUNDS(ROUNDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_in(data_in),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.last_out(last_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Cipher state as the block should hold it.
	logic [63:0]      key01 = '0, key23 = '0, key45 = '0, key67 = '0, nonce01 = '0;
	word_t            start_ctr = '0, nonce2 = '0, blk_ctr = '0;
	logic [POS_W-1:0] byte_pos = '0;
	state_t           keystream = '0;
	logic             ks_ok = 1'b0;

	cipher_byte_t plain_bytes[$];
	cipher_byte_t cipher_due[$];

	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	int results_seen = 0;
	int errors = 0;

	int  send_gap = 0;
	bit  send_calm = 1'b0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  recv_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic word_t rotl(word_t v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t quarter_round(state_t s, int a, int b, int c, int d);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
		return s;
	endfunction

	// Advances the cipher state by one byte and returns the byte that should come out.
	function automatic cipher_byte_t encrypt_byte(logic [7:0] d, logic l);
		state_t init;
		state_t x;
		int r;
		cipher_byte_t res;
		if (!ks_ok) begin
			init[0] = SIGMA0;
			init[1] = SIGMA1;
			init[2] = SIGMA2;
			init[3] = SIGMA3;
			init[4] = key01[31:0];
			init[5] = key01[63:32];
			init[6] = key23[31:0];
			init[7] = key23[63:32];
			init[8] = key45[31:0];
			init[9] = key45[63:32];
			init[10] = key67[31:0];
			init[11] = key67[63:32];
			init[12] = blk_ctr;
			init[13] = nonce01[31:0];
			init[14] = nonce01[63:32];
			init[15] = nonce2;
			x = init;
			for (r = 0; r < ROUNDS; r++) begin
				x = quarter_round(x, 0, 4, 8, 12);
				x = quarter_round(x, 1, 5, 9, 13);
				x = quarter_round(x, 2, 6, 10, 14);
				x = quarter_round(x, 3, 7, 11, 15);
				x = quarter_round(x, 0, 5, 10, 15);
				x = quarter_round(x, 1, 6, 11, 12);
				x = quarter_round(x, 2, 7, 8, 13);
				x = quarter_round(x, 3, 4, 9, 14);
			end
			for (r = 0; r < 16; r++) begin
				keystream[r] = x[r] + init[r];
			end
			ks_ok = 1'b1;
		end
		res.data = d ^ keystream[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8];
		res.last = l;
		if (byte_pos == POS_LAST || l) begin
			blk_ctr = blk_ctr + 1;
			byte_pos = '0;
			ks_ok = 1'b0;
		end else begin
			byte_pos = byte_pos + POS_W'(1);
		end
		return res;
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KEY01: key01 = val;
			REG_KEY23: key23 = val;
			REG_KEY45: key45 = val;
			REG_KEY67: key67 = val;
			REG_COUNTER: begin
				start_ctr = val[31:0];
				blk_ctr = val[31:0];
			end
			REG_NONCE01: nonce01 = val;
			REG_NONCE2: nonce2 = val[31:0];
			default: ;
		endcase
		if (idx != REG_UNUSED) begin
			byte_pos = '0;
			ks_ok = 1'b0;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every byte is through and the block has finished any keystream build.
	task automatic wait_idle();
		while (plain_bytes.size() != 0 || in_valid || cipher_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (BUILD_WAIT) @(posedge clk);
	endtask

	// Input side: one word per handshake, random gap after each accepted word.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (plain_bytes.size() != 0) begin
				in_valid <= 1'b1;
				data_in <= plain_bytes[0].data;
				last_in <= plain_bytes[0].last;
				void'(plain_bytes.pop_front());
				if ($urandom_range(0, 63) == 0) begin
					send_calm = !send_calm;
				end
				send_gap = send_calm ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: random stall per word, plus two long hold-offs that back up the input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_taken) begin
				if ($urandom_range(0, 63) == 0) begin
					recv_calm = !recv_calm;
				end
				stall_left = recv_calm ? 0 : $urandom_range(0, 4);
				if (results_seen == 200 || results_seen == 700) begin
					hold_left = 300;
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cipher_byte_t want;
		in_taken = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (in_taken) begin
			cipher_due.push_back(encrypt_byte(data_in, last_in));
		end
		if (out_taken) begin
			results_seen++;
			if (cipher_due.size() == 0) begin
				$error("unexpected output word: data_out %02h, last_out %0b", data_out, last_out);
				errors++;
			end else begin
				want = cipher_due.pop_front();
				if (data_out !== want.data) begin
					$error("data_out: expected %02h, got %02h", want.data, data_out);
					errors++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %0b, got %0b", want.last, last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		int ph, i, len, n, sel;
		bit with_last;
		logic [63:0] val;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All-zero key, nonce and counter straight out of reset.
		plain_bytes.push_back('{data: 8'h00, last: 1'b0});
		plain_bytes.push_back('{data: 8'hFF, last: 1'b0});
		plain_bytes.push_back('{data: 8'h0F, last: 1'b1});
		plain_bytes.push_back('{data: 8'hF0, last: 1'b1});
		plain_bytes.push_back('{data: 8'h55, last: 1'b0});
		plain_bytes.push_back('{data: 8'hAA, last: 1'b0});
		plain_bytes.push_back('{data: 8'h01, last: 1'b0});
		plain_bytes.push_back('{data: 8'h80, last: 1'b1});
		wait_idle();

		// All-ones settings with the counter at its top, so single-byte messages wrap it.
		write_reg(REG_KEY01, '1);
		write_reg(REG_KEY23, '1);
		write_reg(REG_KEY45, '1);
		write_reg(REG_KEY67, '1);
		write_reg(REG_NONCE01, '1);
		write_reg(REG_NONCE2, '1);
		write_reg(REG_COUNTER, '1);
		plain_bytes.push_back('{data: 8'hFF, last: 1'b1});
		plain_bytes.push_back('{data: 8'h00, last: 1'b1});
		plain_bytes.push_back('{data: 8'h7E, last: 1'b1});
		plain_bytes.push_back('{data: 8'h3C, last: 1'b0});
		plain_bytes.push_back('{data: 8'hC3, last: 1'b0});
		plain_bytes.push_back('{data: 8'h99, last: 1'b0});
		wait_idle();

		// A write to an unused index must leave the message position alone.
		write_reg(REG_UNUSED, {$urandom, $urandom});
		plain_bytes.push_back('{data: 8'h66, last: 1'b0});
		plain_bytes.push_back('{data: 8'hE7, last: 1'b0});
		plain_bytes.push_back('{data: 8'h18, last: 1'b1});

		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			for (i = 0; i < 8; i++) begin
				if ($urandom_range(0, 1) == 1) begin
					sel = $urandom_range(0, 4);
					val = (sel == 0) ? 64'd0 : (sel == 1) ? '1 : {$urandom, $urandom};
					// Counter values at or just below the top make wraps common.
					if (i == REG_COUNTER && sel == 2) begin
						val[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 2);
					end
					write_reg(i[REG_IDX_W-1:0], val);
				end
			end
			n = 0;
			while (n < PHASE_BYTES) begin
				sel = $urandom_range(0, 9);
				if (sel < 4) begin
					len = $urandom_range(1, 8);
				end else if (sel < 8) begin
					len = $urandom_range(9, 70);
				end else begin
					len = $urandom_range(60, 200);
				end
				// Now and then a message runs on into the next one or is cut off by a phase end.
				with_last = ($urandom_range(0, 7) != 0);
				for (i = 0; i < len; i++) begin
					plain_bytes.push_back('{data: 8'($urandom_range(0, 255)),
						last: with_last && (i == len - 1)});
				end
				n += len;
			end
		end

		wait_idle();
		if (cipher_due.size() != 0) begin
			$error("%0d expected output words never arrived", cipher_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
hdl/cc20_pkg.sv
hdl/cc20_round.sv
hdl/cc20_ctrl.sv
hdl/chacha20_stream_xor.sv
verif/tb_chacha20_stream_xor.sv
